FILE: hw/rtl/cddi_pkg.sv
// Shared types and constants for the disc id calculation pipeline.
`timescale 1ns / 1ps

package cddi_pkg;

  localparam int unsigned SECTOR_W = 19;
  localparam int unsigned SECS_W   = 13;  // seconds of any 19-bit sector stay below 6993
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned SUM_W    = 8;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned DSUM_W   = 6;   // four decimal digits sum to at most 36
  localparam int unsigned ID_W     = 32;

  localparam logic [SECTOR_W:0] PREGAP_SECTORS = 20'd150;

  // Division by 75 as a multiply by a rounded-up reciprocal; exact for 20-bit operands.
  localparam int unsigned       DIV75_SHIFT = 27;
  localparam int unsigned       DIV75_PROD_W = 41;
  localparam logic [20:0]       DIV75_MULT  = 21'd1789570;

  // Decimal splitting of a 13-bit seconds value, each exact below 8192.
  localparam int unsigned       DIV10_SHIFT   = 16;
  localparam logic [12:0]       DIV10_MULT    = 13'd6554;
  localparam int unsigned       DIV100_SHIFT  = 19;
  localparam logic [12:0]       DIV100_MULT   = 13'd5243;
  localparam int unsigned       DIV1000_SHIFT = 23;
  localparam logic [13:0]       DIV1000_MULT  = 14'd8389;
  localparam int unsigned       QPROD_W       = 27;

  localparam logic [SUM_W:0]    SUM_MODULUS = 9'd255;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 8'd255;

  typedef struct packed {
    logic [SECTOR_W-1:0] track_start;
    logic [SECTOR_W-1:0] track_end;
    logic                last_track;
  } track_t;

  typedef struct packed {
    logic [SECS_W-1:0] secs;
    logic [LEN_W-1:0]  len;
    logic              last_track;
  } sec_t;

  typedef struct packed {
    logic [SECS_W-1:0] secs;
    logic [9:0]        q10;    // secs / 10
    logic [6:0]        q100;   // secs / 100
    logic [2:0]        q1000;  // secs / 1000
    logic [LEN_W-1:0]  len;
    logic              last_track;
  } quo_t;

endpackage

FILE: hw/rtl/cd_disc_id_calc_unit.sv
// Top level of the disc id calculator: input register, three stages and checks.
`timescale 1ns / 1ps

// The block takes the tracks of a disc's table of contents as words on the
// slave stream, one track per word, and gives one 32-bit disc id word on the
// master stream for each word that carries tlast. Words without tlast give
// no result; they only add to the digit sum and the track count.
// The first sector of the disc is a register written through cfg_we and
// cfg_wdata; it should be written while no track is in flight.
// A track word passes an input register, the divide-by-75 stage, the decimal
// split stage and the accumulator with its result register, which offers the
// id word on the master side. One word can be accepted in every cycle unless a
// result waits there untaken; the rate is set by the accumulator, which takes
// one track per cycle while no last track waits for the result register.
// When the receiver holds m_axis_tready low while a result waits, the block
// keeps taking track words that are not the last of a disc. Once the next
// last track reaches the accumulator it waits there, the three stages in
// front of it fill up, and only then does s_axis_tready drop.
// Reset clears all valid bits, the digit sum, the track count and the first
// sector register; a disc in progress is dropped.

module cd_disc_id_calc_unit import cddi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SECTOR_W-1:0] cfg_wdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,  // track_start [18:0], track_end [37:19], zero pad
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [ID_W-1:0]     m_axis_tdata   // disc_id [31:0]
);

  logic [SECTOR_W-1:0] disc_first_sector;

  logic   in_valid;
  track_t in_reg;
  logic   sec_in_ready;

  logic   sec_valid;
  sec_t   sec_data;
  logic   dig_in_ready;

  logic   quo_valid;
  quo_t   quo_data;
  logic   acc_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      disc_first_sector <= '0;
    end else if (cfg_we) begin
      disc_first_sector <= cfg_wdata;
    end
  end

  // Input register.
  assign s_axis_tready = !in_valid || sec_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_reg.track_start <= s_axis_tdata[SECTOR_W-1:0];
      in_reg.track_end   <= s_axis_tdata[2*SECTOR_W-1:SECTOR_W];
      in_reg.last_track  <= s_axis_tlast;
    end
  end

  cddi_sec_stage u_sec (
    .clk               (clk),
    .rst               (rst),
    .disc_first_sector (disc_first_sector),
    .in_valid          (in_valid),
    .in_data           (in_reg),
    .in_ready          (sec_in_ready),
    .out_valid         (sec_valid),
    .out_data          (sec_data),
    .out_ready         (dig_in_ready)
  );

  cddi_digit_stage u_digit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sec_valid),
    .in_data   (sec_data),
    .in_ready  (dig_in_ready),
    .out_valid (quo_valid),
    .out_data  (quo_data),
    .out_ready (acc_in_ready)
  );

  cddi_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (quo_valid),
    .in_data   (quo_data),
    .in_ready  (acc_in_ready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_ready (m_axis_tready)
  );

  // The input side only stalls behind a result word the receiver has not taken.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // A fresh id counts at least one track, keeps its sum reduced and its gap bits clear.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> (m_axis_tdata[7:0] != 8'd0 && m_axis_tdata[31:24] != 8'hFF
                              && m_axis_tdata[23:21] == 3'b000))
    else $error("malformed disc id word");

  // Seconds of any sector stay within four decimal digits below 7000.
  assert property (@(posedge clk) disable iff (rst)
    sec_valid |-> (sec_data.secs <= 13'd6992 && sec_data.len <= 13'd6990))
    else $error("divide by 75 out of range");

  // The decimal quotients stay within the range that the largest seconds value gives.
  assert property (@(posedge clk) disable iff (rst)
    quo_valid |-> (quo_data.q1000 <= 3'd6 && quo_data.q100 <= 7'd69 && quo_data.q10 <= 10'd699))
    else $error("decimal split out of range");

endmodule

FILE: hw/rtl/cddi_sec_stage.sv
// Seconds and disc length stage: both divisions by 75, registered.
`timescale 1ns / 1ps

module cddi_sec_stage import cddi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [SECTOR_W-1:0] disc_first_sector,
  input  logic                in_valid,
  input  track_t              in_data,
  output logic                in_ready,
  output logic                out_valid,
  output sec_t                out_data,
  input  logic                out_ready
);

  logic [SECTOR_W:0]       start_adj;
  logic [SECTOR_W:0]       end_inc;
  logic [SECTOR_W:0]       first_ext;
  logic [SECTOR_W:0]       len_num;
  logic [DIV75_PROD_W-1:0] secs_prod;
  logic [DIV75_PROD_W-1:0] len_prod;

  always_comb begin
    start_adj = {1'b0, in_data.track_start} + PREGAP_SECTORS;
    end_inc   = {1'b0, in_data.track_end} + {{SECTOR_W{1'b0}}, 1'b1};
    first_ext = {1'b0, disc_first_sector};
    // A last track that ends before the disc start gives a zero length.
    len_num   = (end_inc >= first_ext) ? (end_inc - first_ext) : '0;
    secs_prod = DIV75_PROD_W'(start_adj) * DIV75_PROD_W'(DIV75_MULT);
    len_prod  = DIV75_PROD_W'(len_num) * DIV75_PROD_W'(DIV75_MULT);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.secs       <= secs_prod[DIV75_SHIFT +: SECS_W];
      out_data.len        <= len_prod[DIV75_SHIFT +: LEN_W];
      out_data.last_track <= in_data.last_track;
    end
  end

endmodule

FILE: hw/rtl/cddi_digit_stage.sv
// Decimal split stage: quotients of the seconds by 10, 100 and 1000, registered.
`timescale 1ns / 1ps

module cddi_digit_stage import cddi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  sec_t in_data,
  output logic in_ready,
  output logic out_valid,
  output quo_t out_data,
  input  logic out_ready
);

  logic [QPROD_W-1:0] p10;
  logic [QPROD_W-1:0] p100;
  logic [QPROD_W-1:0] p1000;

  always_comb begin
    p10   = QPROD_W'(in_data.secs) * QPROD_W'(DIV10_MULT);
    p100  = QPROD_W'(in_data.secs) * QPROD_W'(DIV100_MULT);
    p1000 = QPROD_W'(in_data.secs) * QPROD_W'(DIV1000_MULT);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.secs       <= in_data.secs;
      out_data.q10        <= p10[DIV10_SHIFT +: 10];
      out_data.q100       <= p100[DIV100_SHIFT +: 7];
      out_data.q1000      <= p1000[DIV1000_SHIFT +: 3];
      out_data.len        <= in_data.len;
      out_data.last_track <= in_data.last_track;
    end
  end

endmodule

FILE: hw/rtl/cddi_accum.sv
// Digit sum accumulation, track counting and the disc id result register.
`timescale 1ns / 1ps

module cddi_accum import cddi_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  quo_t            in_data,
  output logic            in_ready,
  output logic            out_valid,
  output logic [ID_W-1:0] out_data,
  input  logic            out_ready
);

  logic [SUM_W-1:0]  digit_sum_total;
  logic [CNT_W-1:0]  tracks_seen;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  count_next;
  logic [12:0]       r10;
  logic [9:0]        r100;
  logic [6:0]        r1000;
  logic [3:0]        d0;
  logic [3:0]        d1;
  logic [3:0]        d2;
  logic [DSUM_W-1:0] dsum;
  logic [SUM_W:0]    sum_add;
  logic              take;

  always_comb begin
    r10     = in_data.secs - 13'({3'b0, in_data.q10} * 13'd10);
    r100    = in_data.q10 - 10'({3'b0, in_data.q100} * 10'd10);
    r1000   = in_data.q100 - 7'({4'b0, in_data.q1000} * 7'd10);
    d0      = r10[3:0];
    d1      = r100[3:0];
    d2      = r1000[3:0];
    dsum    = DSUM_W'(d0) + DSUM_W'(d1) + DSUM_W'(d2) + DSUM_W'(in_data.q1000);
    // The running sum stays below 255, so one subtract keeps it reduced.
    sum_add = {1'b0, digit_sum_total} + (SUM_W + 1)'(dsum);
    sum_next = (sum_add >= SUM_MODULUS) ? SUM_W'(sum_add - SUM_MODULUS) : sum_add[SUM_W-1:0];
    count_next = (tracks_seen == COUNT_MAX) ? COUNT_MAX : tracks_seen + 8'd1;
  end

  // Only a last track needs the result register.
  assign in_ready = !in_data.last_track || !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_sum_total <= '0;
      tracks_seen     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (take && in_data.last_track) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (in_data.last_track) begin
          digit_sum_total <= '0;
          tracks_seen     <= '0;
        end else begin
          digit_sum_total <= sum_next;
          tracks_seen     <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_data.last_track) begin
      out_data <= {sum_next, 3'b000, in_data.len, count_next};
    end
  end

endmodule

FILE: tb/cd_disc_id_calc_unit_tb.sv
// Self-checking testbench for the disc id calculator with its own id predictor.
`timescale 1ns / 1ps

// The testbench streams table-of-contents track words into the block and
// computes each expected disc id itself, as the tracks are accepted. The id
// words that come out are compared in order against that prediction.
// Each test is a task of its own. The directed tests cover the following:
//   - the reset value of the first sector register;
//   - seconds values at decimal digit carries and at the largest sector;
//   - lengths that clamp to zero when the end lies before the first sector;
//   - a track count past 255, where the count saturates.
// The random test then runs several register settings. Both sides of the
// stream idle at random, except in one phase where neither side idles.
// The first sector register is only written when the block has drained.

module cd_disc_id_calc_unit_tb;
  import cddi_pkg::*;

  localparam int unsigned CLK_PERIOD      = 8;
  localparam int unsigned RESET_CYCLES    = 7;
  localparam int unsigned IDLE_PCT        = 18;
  localparam int unsigned SETTLE_CYCLES   = 8;     // longer than the pipeline is deep
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned RANDOM_TRACKS   = 570;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned PREGAP          = 150;
  localparam int unsigned SECTORS_PER_SEC = 75;
  localparam int unsigned DIGIT_MOD       = 255;
  localparam int unsigned TRACK_COUNT_MAX = 255;
  localparam logic [SECTOR_W-1:0] SECTOR_MAX = '1;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [SECTOR_W-1:0] cfg_wdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata;   // track_start [18:0], track_end [37:19], zero pad
  logic                s_axis_tlast;   // last track of the disc
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [ID_W-1:0]     m_axis_tdata;   // disc_id [31:0]

  // This is the predictor state, kept in step with the block.
  logic [SECTOR_W-1:0] model_first_sector;
  logic [SUM_W-1:0]    model_digit_sum;
  logic [CNT_W-1:0]    model_track_count;
  logic [ID_W-1:0]     pending_ids[$];
  logic [ID_W-1:0]     expected_id;

  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          no_idle;

  cd_disc_id_calc_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The receiver stalls at random unless a steady phase is running.
  always @(negedge clk) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // The watchdog ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                 input logic [ID_W-1:0] want);
    $display("MISMATCH at %0t: %s got %08h want %08h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Each id word that is taken is compared against the oldest predicted id.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_ids.size() == 0) begin
        report_mismatch("unexpected id word", m_axis_tdata, '0);
      end else begin
        expected_id = pending_ids.pop_front();
        if (m_axis_tdata !== expected_id) begin
          report_mismatch("disc_id", m_axis_tdata, expected_id);
        end
      end
    end
  end

  function automatic int unsigned seconds_digit_sum(input int unsigned secs);
    int unsigned n;
    int unsigned s;
    n = secs;
    s = 0;
    while (n > 0) begin
      s += n % 10;
      n /= 10;
    end
    return s;
  endfunction

  // The predictor takes one accepted track. A last track queues its disc id
  // and clears the sums for the next disc.
  task automatic predict_track(input logic [SECTOR_W-1:0] track_start,
                               input logic [SECTOR_W-1:0] track_end,
                               input logic last_track);
    int unsigned secs;
    int unsigned end_next;
    int unsigned len_secs;
    secs = (int'(track_start) + PREGAP) / SECTORS_PER_SEC;
    model_digit_sum = SUM_W'((int'(model_digit_sum) + seconds_digit_sum(secs)) % DIGIT_MOD);
    if (model_track_count < TRACK_COUNT_MAX) begin
      model_track_count++;
    end
    if (last_track) begin
      end_next = int'(track_end) + 1;
      // The length clamps to zero when the disc ends before its first sector.
      len_secs = (end_next >= int'(model_first_sector)) ?
                 (end_next - int'(model_first_sector)) / SECTORS_PER_SEC : 0;
      pending_ids.push_back((32'(model_digit_sum) << 24) | (len_secs << 8) |
                            32'(model_track_count));
      model_digit_sum   = '0;
      model_track_count = '0;
    end
  endtask

  // This task offers one track word, perhaps after a few idle cycles, and
  // returns at the edge where it is taken.
  task automatic send_track(input logic [SECTOR_W-1:0] track_start,
                            input logic [SECTOR_W-1:0] track_end,
                            input logic last_track);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, track_end, track_start};
    s_axis_tlast  <= last_track;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_track(track_start, track_end, last_track);
  endtask

  // The sender stops and waits for every predicted id. With settle set, it
  // also lets the pipeline empty of trailing tracks that give no word.
  task automatic wait_results(input bit settle);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_ids.size() != 0) @(posedge clk);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  task automatic write_first_sector(input logic [SECTOR_W-1:0] sector);
    wait_results(1'b1);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= sector;
    @(posedge clk);
    model_first_sector = sector;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [SECTOR_W-1:0] random_sector();
    return SECTOR_W'($urandom_range(0, int'(SECTOR_MAX)));
  endfunction

  // A disc is sent either as realistic rising track starts, or as
  // independent random fields.
  task automatic send_disc(input int unsigned track_total, input bit realistic);
    int unsigned pos;
    logic [SECTOR_W-1:0] start_sector;
    logic [SECTOR_W-1:0] end_sector;
    pos = $urandom_range(0, 600);
    for (int unsigned i = 0; i < track_total; i++) begin
      if (realistic) begin
        start_sector = (pos > int'(SECTOR_MAX)) ? SECTOR_MAX : SECTOR_W'(pos);
        pos += $urandom_range(150, 30000);
        end_sector = (pos > int'(SECTOR_MAX)) ? SECTOR_MAX : SECTOR_W'(pos - 1);
      end else begin
        start_sector = random_sector();
        end_sector   = random_sector();
      end
      send_track(start_sector, end_sector, i == track_total - 1);
    end
  endtask

  // The first sector keeps its reset value of zero here.
  task automatic test_reset_first_sector();
    send_track('0, '0, 1'b1);
    send_track(SECTOR_MAX, SECTOR_MAX, 1'b1);
  endtask

  // These starts give seconds values of 2, 9, 10, 99, 100, 999, 1000,
  // 4999 and the largest one, 6992.
  task automatic test_digit_carries();
    write_first_sector('0);
    send_track('0, random_sector(), 1'b0);
    send_track(19'd74, random_sector(), 1'b0);
    send_track(19'd525, random_sector(), 1'b0);
    send_track(19'd600, random_sector(), 1'b0);
    send_track(19'd7275, random_sector(), 1'b0);
    send_track(19'd7350, random_sector(), 1'b0);
    send_track(19'd74775, random_sector(), 1'b0);
    send_track(19'd74850, random_sector(), 1'b0);
    send_track(SECTOR_MAX, random_sector(), 1'b0);
    send_track(19'd374775, 19'd449999, 1'b1);
  endtask

  // These lengths fall near zero: the end lies before the first sector, the
  // end lies just at it, and the span is exactly 75 sectors or one below.
  task automatic test_length_bounds();
    write_first_sector(SECTOR_MAX);
    send_track('0, '0, 1'b1);
    send_track(19'd1000, SECTOR_MAX - 1, 1'b1);
    send_track(19'd5, SECTOR_MAX, 1'b1);
    write_first_sector(19'd150);
    send_track(19'd150, 19'd224, 1'b1);
    send_track(19'd150, 19'd223, 1'b1);
    send_track('0, 19'd148, 1'b1);
  endtask

  // One disc runs past the count limit, and one disc reaches it exactly.
  task automatic test_count_saturation();
    write_first_sector(SECTOR_W'($urandom_range(0, 2000)));
    send_disc(260, 1'b0);
    send_disc(255, 1'b1);
    send_disc(1, 1'b0);
  endtask

  task automatic test_random_discs();
    int unsigned phase_tracks;
    int unsigned disc_tracks;
    int unsigned pick;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       write_first_sector('0);
        1:       write_first_sector(SECTOR_MAX);
        3:       write_first_sector(SECTOR_W'($urandom_range(0, 1000)));
        default: write_first_sector(random_sector());
      endcase
      // In this phase neither side of the stream idles.
      no_idle = (phase == 2);
      phase_tracks = 0;
      while (phase_tracks < RANDOM_TRACKS / RANDOM_PHASES) begin
        pick = $urandom_range(99);
        if (pick < 2) begin
          disc_tracks = $urandom_range(250, 270);
        end else if (pick < 20) begin
          disc_tracks = 1;
        end else begin
          disc_tracks = $urandom_range(2, 25);
        end
        send_disc(disc_tracks, 1'($urandom_range(1)));
        phase_tracks += disc_tracks;
        // Now and then the sender holds back until every id has come out.
        if ($urandom_range(7) == 0) begin
          wait_results(1'b0);
        end
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    s_axis_tvalid      = 1'b0;
    s_axis_tdata       = '0;
    s_axis_tlast       = 1'b0;
    m_axis_tready      = 1'b0;
    model_first_sector = '0;
    model_digit_sum    = '0;
    model_track_count  = '0;
    mismatches         = 0;
    quiet_cycles       = 0;
    no_idle            = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_first_sector();
    test_digit_carries();
    test_length_bounds();
    test_count_saturation();
    test_random_discs();

    wait_results(1'b1);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/cddi_pkg.sv
hw/rtl/cddi_sec_stage.sv
hw/rtl/cddi_digit_stage.sv
hw/rtl/cddi_accum.sv
hw/rtl/cd_disc_id_calc_unit.sv
tb/cd_disc_id_calc_unit_tb.sv
